// File: rtl/amcd_pkg.sv
package amcd_pkg;

  // Chunk ids, gathered first byte lowest
  localparam logic [31:0] ID_AUDIO = 32'h6277_3130;
  localparam logic [31:0] ID_VIDEO = 32'h6364_3030;

  // Audio block length in bytes (1 .. 65536)
  localparam int unsigned BLOCK_BYTES = 2048;
  localparam int unsigned FILL_W      = 16;

  // Queue between parser and output stage
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [7:0] KEEP_RESET = 8'd1;

  localparam logic STREAM_AUDIO = 1'b0;
  localparam logic STREAM_VIDEO = 1'b1;

  // Payload routing of the current chunk
  typedef enum logic [2:0] {
    ROUTE_DROP  = 3'b001,
    ROUTE_AUDIO = 3'b010,
    ROUTE_VIDEO = 3'b100
  } route_t;

  // One classified payload byte
  typedef struct packed {
    logic [7:0] data;
    logic       stream;
    logic       frame_last;
    logic       restart;    // list restarted since the previous queued byte
  } amcd_item_t;

endpackage

// File: rtl/amcd_in_if.sv
interface amcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       list_start;

  modport source (output valid, in_byte, list_start, input ready);
  modport sink   (input valid, in_byte, list_start, output ready);
endinterface

// File: rtl/amcd_out_if.sv
interface amcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_stream;
  logic       frame_last;
  logic       block_last;

  modport source (output valid, out_byte, out_stream, frame_last, block_last, input ready);
  modport sink   (input valid, out_byte, out_stream, frame_last, block_last, output ready);
endinterface

// File: rtl/amcd_cfg_if.sv
interface amcd_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] video_keep_every;

  modport source (output valid, video_keep_every, input ready);
  modport sink   (input valid, video_keep_every, output ready);
endinterface

// File: rtl/amcd_front.sv
module amcd_front
  import amcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  amcd_in_if.sink    in_ch,
  amcd_cfg_if.sink   cfg,
  input  logic       q_full,
  output logic       push,
  output amcd_item_t push_item
);

  logic [7:0]  video_keep_every;
  logic [2:0]  phase, phase_next;
  logic [31:0] id_shift, id_shift_next;
  logic [31:0] bytes_left, bytes_left_next;
  route_t      route, route_next;
  logic [7:0]  frame_count, frame_count_next;
  logic        odd_offset, odd_offset_next;
  logic        id_audio, id_audio_next;
  logic        id_video, id_video_next;
  logic        restart_pend, restart_pend_next;

  logic        accept;
  logic [2:0]  phase_e;
  logic [31:0] shift_e, left_e, shift_new;
  route_t      route_e;
  logic [7:0]  fc_e, keep;
  logic [8:0]  fc_inc;
  logic        odd_e, aud_e, vid_e, restart_e;

  assign cfg.ready   = 1'b1;
  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      video_keep_every <= KEEP_RESET;
    end else if (cfg.valid && cfg.ready) begin
      video_keep_every <= cfg.video_keep_every;
    end
  end

  // Parse one byte: header gather, pad skip, payload routing
  always_comb begin
    phase_e   = in_ch.list_start ? 3'd0 : phase;
    shift_e   = in_ch.list_start ? 32'd0 : id_shift;
    left_e    = in_ch.list_start ? 32'd0 : bytes_left;
    route_e   = in_ch.list_start ? ROUTE_DROP : route;
    fc_e      = in_ch.list_start ? 8'd0 : frame_count;
    odd_e     = in_ch.list_start ? 1'b0 : odd_offset;
    aud_e     = in_ch.list_start ? 1'b0 : id_audio;
    vid_e     = in_ch.list_start ? 1'b0 : id_video;
    restart_e = in_ch.list_start || restart_pend;

    keep      = (video_keep_every == 8'd0) ? 8'd1 : video_keep_every;
    fc_inc    = {1'b0, fc_e} + 9'd1;
    shift_new = shift_e | ({24'd0, in_ch.in_byte} << {phase_e[1:0], 3'b000});

    phase_next        = phase;
    id_shift_next     = id_shift;
    bytes_left_next   = bytes_left;
    route_next        = route;
    frame_count_next  = frame_count;
    odd_offset_next   = odd_offset;
    id_audio_next     = id_audio;
    id_video_next     = id_video;
    restart_pend_next = restart_pend;

    push                 = 1'b0;
    push_item.data       = in_ch.in_byte;
    push_item.stream     = STREAM_AUDIO;
    push_item.frame_last = 1'b0;
    push_item.restart    = restart_e;

    if (accept) begin
      phase_next        = phase_e;
      id_shift_next     = shift_e;
      bytes_left_next   = left_e;
      route_next        = route_e;
      frame_count_next  = fc_e;
      odd_offset_next   = !odd_e;
      id_audio_next     = aud_e;
      id_video_next     = vid_e;
      restart_pend_next = restart_e;

      if (left_e != 32'd0) begin
        // Payload byte
        bytes_left_next = left_e - 32'd1;
        case (route_e)
          ROUTE_AUDIO: begin
            push = 1'b1;
          end
          ROUTE_VIDEO: begin
            push                 = 1'b1;
            push_item.stream     = STREAM_VIDEO;
            push_item.frame_last = (left_e == 32'd1);
          end
          default: begin
            push = 1'b0;
          end
        endcase
      end else if (!(phase_e == 3'd0 && odd_e)) begin
        // Header byte; a pad byte at odd offset falls through and is dropped
        phase_next    = phase_e + 3'd1;
        id_shift_next = shift_new;
        if (phase_e == 3'd3) begin
          id_audio_next = (shift_new == ID_AUDIO);
          id_video_next = (shift_new == ID_VIDEO);
          id_shift_next = 32'd0;
        end else if (phase_e == 3'd7) begin
          id_shift_next   = 32'd0;
          bytes_left_next = shift_new;
          route_next      = ROUTE_DROP;
          if (aud_e) begin
            route_next = ROUTE_AUDIO;
          end else if (vid_e) begin
            if (fc_e == 8'd0) begin
              route_next = ROUTE_VIDEO;
            end
            frame_count_next = (fc_inc >= {1'b0, keep}) ? 8'd0 : fc_inc[7:0];
          end
        end
      end

      if (push) begin
        restart_pend_next = 1'b0;
      end
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= 3'd0;
      id_shift     <= 32'd0;
      bytes_left   <= 32'd0;
      route        <= ROUTE_DROP;
      frame_count  <= 8'd0;
      odd_offset   <= 1'b0;
      id_audio     <= 1'b0;
      id_video     <= 1'b0;
      restart_pend <= 1'b0;
    end else begin
      phase        <= phase_next;
      id_shift     <= id_shift_next;
      bytes_left   <= bytes_left_next;
      route        <= route_next;
      frame_count  <= frame_count_next;
      odd_offset   <= odd_offset_next;
      id_audio     <= id_audio_next;
      id_video     <= id_video_next;
      restart_pend <= restart_pend_next;
    end
  end

  // Header phase stays at zero while inside a payload
  a_phase_in_payload: assert property (@(posedge clk) disable iff (rst)
    (bytes_left != 32'd0) |-> (phase == 3'd0))
    else $error("header phase advanced inside a payload");

  // A chunk id cannot be both audio and video
  a_id_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(id_audio && id_video))
    else $error("chunk id classified as both streams");

  // A push never happens without an accepted byte
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    push |-> accept)
    else $error("queue push without accepted request");

endmodule

// File: rtl/amcd_fifo.sv
module amcd_fifo
  import amcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  amcd_item_t push_item,
  output logic       full,
  input  logic       pop,
  output logic       empty,
  output amcd_item_t head_item
);

  amcd_item_t            mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full      = (count == QUEUE_AW'(0) + (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign head_item = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem[wr_ptr] <= push_item;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + QUEUE_AW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + QUEUE_AW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + (QUEUE_AW+1)'(1);
        2'b01:   count <= count - (QUEUE_AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  // Occupancy never exceeds the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // No request is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("push into full queue");

  // Pointer distance matches the occupancy count
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr - rd_ptr) == count[QUEUE_AW-1:0])
    else $error("queue pointers disagree with count");

endmodule

// File: rtl/amcd_back.sv
module amcd_back
  import amcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_empty,
  output logic       q_pop,
  input  amcd_item_t head_item,
  amcd_out_if.source out_ch
);

  logic [FILL_W-1:0] block_fill, block_fill_next;
  logic [FILL_W-1:0] fill_base;
  logic [FILL_W:0]   fill_inc;
  logic              blk_last;
  logic              load;

  // Load output register when it is free or being drained
  assign load  = !q_empty && (!out_ch.valid || out_ch.ready);
  assign q_pop = load;

  // Count audio bytes within the current block
  always_comb begin
    fill_base       = head_item.restart ? '0 : block_fill;
    fill_inc        = {1'b0, fill_base} + (FILL_W+1)'(1);
    blk_last        = 1'b0;
    block_fill_next = block_fill;
    if (load) begin
      block_fill_next = fill_base;
      if (head_item.stream == STREAM_AUDIO) begin
        blk_last        = (fill_inc >= (FILL_W+1)'(BLOCK_BYTES));
        block_fill_next = blk_last ? '0 : fill_inc[FILL_W-1:0];
      end
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
      block_fill   <= '0;
    end else begin
      block_fill <= block_fill_next;
      if (load) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_ch.out_byte   <= head_item.data;
      out_ch.out_stream <= head_item.stream;
      out_ch.frame_last <= head_item.frame_last;
      out_ch.block_last <= blk_last;
    end
  end

  // Block mark only on audio, frame mark only on video
  a_block_last_audio: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.block_last) |-> (out_ch.out_stream == STREAM_AUDIO))
    else $error("block mark on video byte");

  a_frame_last_video: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.frame_last) |-> (out_ch.out_stream == STREAM_VIDEO))
    else $error("frame mark on audio byte");

  // Fill count stays below one block
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, block_fill} < (FILL_W+1)'(BLOCK_BYTES))
    else $error("audio block fill out of range");

endmodule

// File: rtl/avi_movi_chunk_demux.sv
// AVI movi list chunk demultiplexer.
// in_ch: one byte of the movi list per request; list_start on the first byte of
//   a list restarts the chunk parser, the video keep cycle, the audio block
//   count and the pad parity.
// cfg: one write request sets video_keep_every (keep one video chunk out of
//   that many; 0 behaves as 1). Write it only while the block is idle.
// out_ch: payload bytes of audio ('01wb', out_stream 0) and kept video
//   ('00dc', out_stream 1) chunks. block_last marks every BLOCK_BYTES-th audio
//   byte, frame_last the last byte of a kept video frame. Header bytes, pad
//   bytes, dropped frames and other chunks produce nothing.
// Throughput: one byte per cycle on both sides while out_ch is ready and the
//   queue is not full. An accepted payload byte reaches out_ch through the
//   parser's queue write and the output register.
// When out_ch stalls, the four-entry queue absorbs bytes; in_ch.ready drops
//   once it is full. Reset empties the queue, clears the parser and sets
//   video_keep_every to 1; there is no clearing pass.
module avi_movi_chunk_demux
  import amcd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  amcd_in_if.sink     in_ch,
  amcd_cfg_if.sink    cfg,
  amcd_out_if.source  out_ch
);

  logic       q_push, q_full, q_pop, q_empty;
  amcd_item_t push_item, head_item;

  amcd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_ch     (in_ch),
    .cfg       (cfg),
    .q_full    (q_full),
    .push      (q_push),
    .push_item (push_item)
  );

  amcd_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_item (head_item)
  );

  amcd_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .head_item (head_item),
    .out_ch    (out_ch)
  );

endmodule

// File: tb/sv/amcd_demux_checker.sv
`timescale 1ns / 1ps

module amcd_demux_checker
  import amcd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  amcd_in_if         in_ch,
  amcd_cfg_if        cfg,
  amcd_out_if        out_ch,
  output int         fails,
  output int         pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       stream;
    logic       frame_last;
    logic       block_last;
  } routed_byte_t;

  // Mirror of the parser state
  logic [7:0]   keep_every;
  logic [2:0]   hdr_pos;
  logic [31:0]  hdr_shift;
  logic [31:0]  chunk_tag;
  logic [31:0]  payload_left;
  route_t       cur_route;
  logic [7:0]   frame_pos;
  int unsigned  block_fill_cnt;
  logic         odd_pos;

  routed_byte_t routed_q[$];
  int           mismatch_cnt = 0;

  // Clear everything a list start restarts
  task automatic restart_list();
    hdr_pos        = '0;
    hdr_shift      = '0;
    chunk_tag      = '0;
    payload_left   = '0;
    cur_route      = ROUTE_DROP;
    frame_pos      = '0;
    block_fill_cnt = 0;
    odd_pos        = 1'b0;
  endtask

  // Advance the parser by one byte and queue the routed byte, if any
  task automatic route_byte(input logic [7:0] b, input logic first);
    logic        parity;
    logic        last;
    int unsigned keep;
    int unsigned fill;
    if (first) begin
      restart_list();
    end
    parity  = odd_pos;
    odd_pos = ~odd_pos;
    if (payload_left != 0) begin
      payload_left = payload_left - 1;
      if (cur_route == ROUTE_AUDIO) begin
        fill = block_fill_cnt + 1;
        last = (fill >= BLOCK_BYTES);
        if (last) begin
          fill = 0;
        end
        block_fill_cnt = fill;
        routed_q.push_back('{data: b, stream: STREAM_AUDIO, frame_last: 1'b0,
                             block_last: last});
      end else if (cur_route == ROUTE_VIDEO) begin
        routed_q.push_back('{data: b, stream: STREAM_VIDEO,
                             frame_last: (payload_left == 0), block_last: 1'b0});
      end
    end else if (!(hdr_pos == 0 && parity)) begin
      // Gather id, then size, lowest byte first
      hdr_shift = hdr_shift | (32'(b) << (8 * hdr_pos[1:0]));
      hdr_pos   = hdr_pos + 3'd1;
      if (hdr_pos == 3'd4) begin
        chunk_tag = hdr_shift;
        hdr_shift = '0;
      end else if (hdr_pos == 3'd0) begin
        keep      = (keep_every == 0) ? 1 : keep_every;
        cur_route = ROUTE_DROP;
        if (chunk_tag == ID_AUDIO) begin
          cur_route = ROUTE_AUDIO;
        end else if (chunk_tag == ID_VIDEO) begin
          if (frame_pos == 0) begin
            cur_route = ROUTE_VIDEO;
          end
          frame_pos = (int'(frame_pos) + 1 >= keep) ? 8'd0 : frame_pos + 8'd1;
        end
        payload_left = hdr_shift;
        hdr_shift    = '0;
      end
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Watch config writes, byte requests and routed output
  always @(posedge clk) begin : watch
    routed_byte_t want;
    if (rst) begin
      keep_every = KEEP_RESET;
      restart_list();
      routed_q.delete();
    end else begin
      if (cfg.valid && cfg.ready) begin
        keep_every = cfg.video_keep_every;
      end
      if (in_ch.valid && in_ch.ready) begin
        route_byte(in_ch.in_byte, in_ch.list_start);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (routed_q.size() == 0) begin
          $error("unexpected output byte %0h on stream %0b", out_ch.out_byte,
                 out_ch.out_stream);
          mismatch_cnt++;
        end else begin
          want = routed_q.pop_front();
          check_field("out_byte", want.data, out_ch.out_byte);
          check_field("out_stream", 8'(want.stream), 8'(out_ch.out_stream));
          check_field("frame_last", 8'(want.frame_last), 8'(out_ch.frame_last));
          check_field("block_last", 8'(want.block_last), 8'(out_ch.block_last));
        end
      end
    end
    fails   <= mismatch_cnt;
    pending <= routed_q.size();
  end

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
  import amcd_pkg::*;

  logic clk;
  logic rst;

  amcd_in_if  in_ch();
  amcd_cfg_if cfg();
  amcd_out_if out_ch();

  int chk_fails;
  int chk_pending;

  int send_idle;
  int recv_idle;
  bit odd_pos;
  bit list_open;
  int sent;

  avi_movi_chunk_demux u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .cfg    (cfg),
    .out_ch (out_ch)
  );

  amcd_demux_checker u_chk (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .cfg     (cfg),
    .out_ch  (out_ch),
    .fails   (chk_fails),
    .pending (chk_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #10_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // Stall the output side at random
  always @(posedge clk) begin
    out_ch.ready <= !rst && ($urandom_range(99) >= recv_idle);
  end

  // Send one byte request, with random gaps ahead of it
  task automatic send_byte(input logic [7:0] b, input bit first);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.in_byte    <= b;
    in_ch.list_start <= first;
    do @(posedge clk); while (!in_ch.ready);
    if (first) begin
      odd_pos = 1'b0;
    end
    odd_pos = ~odd_pos;
    sent++;
  endtask

  // Pad to an even offset, then send id and size, lowest byte first
  task automatic send_header(input logic [31:0] id, input logic [31:0] size,
                             input bit first);
    logic [63:0] hdr;
    hdr = {size, id};
    if (!first && odd_pos) begin
      send_byte(8'($urandom_range(255)), 1'b0);
    end
    for (int k = 0; k < 8; k++) begin
      send_byte(hdr[8*k +: 8], first && (k == 0));
    end
  endtask

  task automatic send_payload(input int n);
    repeat (n) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  // Pick a chunk id: mostly audio and video, some unknown or near misses
  function automatic logic [31:0] pick_id();
    int r;
    r = $urandom_range(99);
    if (r < 40) return ID_AUDIO;
    if (r < 80) return ID_VIDEO;
    if (r < 90) return ID_VIDEO ^ (32'd1 << $urandom_range(31));
    return $urandom;
  endfunction

  // One list: well-formed chunks, sometimes cut short by noise or a huge size
  task automatic random_list(input bit first);
    int          n_chunks;
    int          r;
    logic [31:0] size;
    n_chunks = $urandom_range(1, 12);
    for (int c = 0; c < n_chunks; c++) begin
      r = $urandom_range(99);
      if (r < 3) begin
        size = $urandom_range(1) ? 32'hFFFF_FFFF : ($urandom | 32'h8000_0000);
        send_header(pick_id(), size, first);
        send_payload($urandom_range(6));
        list_open = 1'b0;
        return;
      end
      if (r < 6) begin
        send_byte(8'($urandom_range(255)), first);
        send_payload($urandom_range(1, 7));
        list_open = 1'b0;
        return;
      end
      r = $urandom_range(99);
      if (r < 10) begin
        size = 0;
      end else if (r < 90) begin
        size = $urandom_range(1, 24);
      end else begin
        size = $urandom_range(25, 80);
      end
      send_header(pick_id(), size, first);
      send_payload(size);
      first = 1'b0;
    end
    list_open = 1'b1;
  endtask

  // Hold off until every expected byte is out or the wait gives up, then let the pipe empty
  task automatic settle();
    int waited;
    in_ch.valid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (chk_pending != 0 && waited < 5000);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_keep(input logic [7:0] v);
    cfg.valid            <= 1'b1;
    cfg.video_keep_every <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] keep_plan [6];
    int         phase_end;
    keep_plan = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd2, 8'($urandom_range(4, 254))};
    rst                  <= 1'b1;
    in_ch.valid          <= 1'b0;
    in_ch.in_byte        <= '0;
    in_ch.list_start     <= 1'b0;
    cfg.valid            <= 1'b0;
    cfg.video_keep_every <= '0;
    send_idle = 22;
    recv_idle = 67;
    odd_pos   = 1'b0;
    list_open = 1'b0;
    sent      = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      settle();
      if (p < 2) begin
        send_idle = 22;
        recv_idle = 67;
      end else if (p < 4) begin
        send_idle = 67;
        recv_idle = 22;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      write_keep(keep_plan[p]);

      if (p == 0) begin
        // Directed: byte extremes, pad byte, short video frame, empty video chunk
        send_header(ID_AUDIO, 32'd1, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_header(ID_VIDEO, 32'd2, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_header(ID_VIDEO, 32'd0, 1'b0);
        list_open = 1'b1;
      end

      if (p == 3) begin
        // Long audio run across at least two block boundaries
        send_header(ID_AUDIO, 32'd4100, !list_open);
        send_payload(4100);
        list_open = 1'b1;
      end

      phase_end = sent + 225;
      while (sent < phase_end) begin
        random_list(!list_open || ($urandom_range(3) == 0));
      end
    end

    settle();
    if (chk_pending != 0) begin
      $error("%0d expected output bytes never arrived", chk_pending);
    end
    if (chk_fails == 0 && chk_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/amcd_pkg.sv
rtl/amcd_in_if.sv
rtl/amcd_out_if.sv
rtl/amcd_cfg_if.sv
rtl/amcd_front.sv
rtl/amcd_fifo.sv
rtl/amcd_back.sv
rtl/avi_movi_chunk_demux.sv
tb/sv/amcd_demux_checker.sv
tb/sv/tb.sv
